[hw/rtl/rgbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared constants and types of the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int COEF_FRAC_BITS = 8;
  localparam int COEF_BITS      = 16;

  localparam int LINE_DEPTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int MAX_HEIGHT = 1024;

  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int POS_W   = 10;
  localparam int GEOM_W  = 11;
  localparam int KROW_W  = 48;

  localparam int PROD_W   = COEF_BITS + CHAN_W + 1;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int SUM_W    = PROD_W + 4;
  localparam int TRUNC_W  = SUM_W - COEF_FRAC_BITS;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;

  localparam logic [GEOM_W-1:0] WIDTH_RESET   = GEOM_W'(640);
  localparam logic [GEOM_W-1:0] HEIGHT_RESET  = GEOM_W'(480);
  localparam logic [KROW_W-1:0] KMID_RESET    =
    KROW_W'(1) << (COEF_BITS + COEF_FRAC_BITS);
  localparam logic [CHAN_W-1:0] CEILING_RESET = CHAN_W'(250);
  localparam logic [GEOM_W-1:0] GEOM_MIN      = GEOM_W'(3);

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [POS_W-1:0]  pos_t;

  // red in the low bits
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    pos_t   column;
    pos_t   row;
    logic   last;
  } result_t;

  typedef struct packed {
    pixel_t centre;
    pixel_t newer;
    pixel_t pix;
    pos_t   column;
    pos_t   row;
    logic   emit_prev;
    logic   do_conv;
    logic   emit_rowend;
    logic   emit_self;
  } stage_meta_t;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_KERNEL_TOP,
    REG_KERNEL_MIDDLE,
    REG_KERNEL_BOTTOM,
    REG_PIXEL_CEILING
  } cfg_reg_t;

endpackage

[hw/rtl/rgbc_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc stream interfaces
// Valid/ready channels for input pixels and output result beats.
// ----------------------------------------------------------------------------
interface rgbc_pixel_if;
  logic            valid;
  logic            ready;
  rgbc_pkg::chan_t red_in;
  rgbc_pkg::chan_t green_in;
  rgbc_pkg::chan_t blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rgbc_result_if;
  logic            valid;
  logic            ready;
  rgbc_pkg::chan_t out_red;
  rgbc_pkg::chan_t out_green;
  rgbc_pkg::chan_t out_blue;
  rgbc_pkg::pos_t  out_column;
  rgbc_pkg::pos_t  out_row;
  logic            last_of_run;

  modport source (output valid, out_red, out_green, out_blue, out_column, out_row,
                  last_of_run, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_column, out_row,
                last_of_run, output ready);
endinterface

[hw/rtl/rgb_convolution_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_convolution_3x3
// Streaming 3x3 convolution over an RGB raster with border pass-through.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while each pixel causes at most
// one result and result.ready is high. The two previous rows live in a single
// line store (one 48-bit entry per column), read when a pixel is accepted and
// written back as the pixel leaves the window stage; no clearing pass is
// needed after reset. Results pass the s1, s2, s3 and result slot registers
// before the output register. A pixel at the end of a row or in the last row
// causes up to three results, which the single output register drains at one
// beat per cycle while result.ready is high, holding input off until the last
// is taken. Writing frame_width or frame_height starts a new frame.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3 (
  input  logic                                 clk,
  input  logic                                 rst,
  rgbc_pixel_if.sink                           pixel,
  rgbc_result_if.source                        result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rgbc_pkg::CFG_AW-1:0]          paddr,
  input  logic [rgbc_pkg::CFG_DW-1:0]          pwdata,
  output logic [rgbc_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);

  // configuration
  logic [rgbc_pkg::GEOM_W-1:0] frame_width;
  logic [rgbc_pkg::GEOM_W-1:0] frame_height;
  logic [rgbc_pkg::KROW_W-1:0] kernel_row_top;
  logic [rgbc_pkg::KROW_W-1:0] kernel_row_middle;
  logic [rgbc_pkg::KROW_W-1:0] kernel_row_bottom;
  rgbc_pkg::chan_t             pixel_ceiling;

  logic                cfg_write;
  rgbc_pkg::cfg_reg_t  cfg_sel;
  logic                geom_write;

  logic [rgbc_pkg::GEOM_W-1:0] eff_w;
  logic [rgbc_pkg::GEOM_W-1:0] eff_h;
  rgbc_pkg::pos_t              last_col;
  rgbc_pkg::pos_t              last_row;

  // counters and pipeline
  rgbc_pkg::pos_t col;
  rgbc_pkg::pos_t row;
  rgbc_pkg::pos_t col_next;
  rgbc_pkg::pos_t row_next;

  logic en;
  logic accept;

  logic                           s1_valid;
  rgbc_pkg::pixel_t               s1_pix;
  rgbc_pkg::pos_t                 s1_col;
  rgbc_pkg::pos_t                 s1_row;
  logic [2*rgbc_pkg::PIXEL_W-1:0] line_rd;
  rgbc_pkg::pixel_t               clipped;

  logic [2*rgbc_pkg::PIXEL_W-1:0] line_store [rgbc_pkg::LINE_DEPTH];

  rgbc_pkg::pixel_t win_far  [3];
  rgbc_pkg::pixel_t win_near [3];
  rgbc_pkg::pixel_t col_new  [3];
  rgbc_pkg::pixel_t grid     [3][3];
  logic [rgbc_pkg::KROW_W-1:0] krow [3];

  logic signed [rgbc_pkg::PROD_W-1:0] prod      [3][3][3];
  logic signed [rgbc_pkg::PROD_W-1:0] s2_prod   [3][3][3];
  logic signed [rgbc_pkg::ROWSUM_W-1:0] rowsum  [3][3];
  logic signed [rgbc_pkg::ROWSUM_W-1:0] s3_rowsum [3][3];
  logic signed [rgbc_pkg::SUM_W-1:0]  total     [3];
  rgbc_pkg::chan_t                    conv_chan [3];

  rgbc_pkg::stage_meta_t s1_meta;
  rgbc_pkg::stage_meta_t s2_meta;
  rgbc_pkg::stage_meta_t s3_meta;
  logic                  s2_valid;
  logic                  s3_valid;

  // result slots and output register
  rgbc_pkg::result_t slot_new [3];
  rgbc_pkg::result_t res_slot [3];
  logic [2:0]        res_valid;
  logic [2:0]        sel_mask;
  logic [2:0]        rem_mask;
  logic [1:0]        sel_idx;
  logic              out_take;
  logic              pop;
  logic              last_sel;
  rgbc_pkg::pixel_t  conv_pix;
  rgbc_pkg::result_t out_pick;

  logic              out_valid;
  rgbc_pkg::result_t out_data;

  function automatic rgbc_pkg::chan_t clip_sum(
    input logic signed [rgbc_pkg::SUM_W-1:0] s,
    input rgbc_pkg::chan_t                   lim
  );
    logic [rgbc_pkg::TRUNC_W-1:0] t;
    t = s[rgbc_pkg::SUM_W-1:rgbc_pkg::COEF_FRAC_BITS];
    if (s <= 0) begin
      return '0;
    end else if (t > rgbc_pkg::TRUNC_W'(lim)) begin
      return lim;
    end
    return t[rgbc_pkg::CHAN_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite;
  assign cfg_sel    = rgbc_pkg::cfg_reg_t'(paddr[rgbc_pkg::CFG_AW-1:3]);
  assign geom_write = cfg_write &&
                      (cfg_sel == rgbc_pkg::REG_FRAME_WIDTH ||
                       cfg_sel == rgbc_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= rgbc_pkg::WIDTH_RESET;
      frame_height      <= rgbc_pkg::HEIGHT_RESET;
      kernel_row_top    <= '0;
      kernel_row_middle <= rgbc_pkg::KMID_RESET;
      kernel_row_bottom <= '0;
      pixel_ceiling     <= rgbc_pkg::CEILING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        rgbc_pkg::REG_FRAME_WIDTH:   frame_width <= pwdata[rgbc_pkg::GEOM_W-1:0];
        rgbc_pkg::REG_FRAME_HEIGHT:  frame_height <= pwdata[rgbc_pkg::GEOM_W-1:0];
        rgbc_pkg::REG_KERNEL_TOP:    kernel_row_top <= pwdata[rgbc_pkg::KROW_W-1:0];
        rgbc_pkg::REG_KERNEL_MIDDLE: kernel_row_middle <= pwdata[rgbc_pkg::KROW_W-1:0];
        rgbc_pkg::REG_KERNEL_BOTTOM: kernel_row_bottom <= pwdata[rgbc_pkg::KROW_W-1:0];
        rgbc_pkg::REG_PIXEL_CEILING: pixel_ceiling <= pwdata[rgbc_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      rgbc_pkg::REG_FRAME_WIDTH:   prdata = rgbc_pkg::CFG_DW'(frame_width);
      rgbc_pkg::REG_FRAME_HEIGHT:  prdata = rgbc_pkg::CFG_DW'(frame_height);
      rgbc_pkg::REG_KERNEL_TOP:    prdata = rgbc_pkg::CFG_DW'(kernel_row_top);
      rgbc_pkg::REG_KERNEL_MIDDLE: prdata = rgbc_pkg::CFG_DW'(kernel_row_middle);
      rgbc_pkg::REG_KERNEL_BOTTOM: prdata = rgbc_pkg::CFG_DW'(kernel_row_bottom);
      rgbc_pkg::REG_PIXEL_CEILING: prdata = rgbc_pkg::CFG_DW'(pixel_ceiling);
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_width < rgbc_pkg::GEOM_MIN) begin
      eff_w = rgbc_pkg::GEOM_MIN;
    end else if (frame_width > rgbc_pkg::GEOM_W'(rgbc_pkg::LINE_DEPTH)) begin
      eff_w = rgbc_pkg::GEOM_W'(rgbc_pkg::LINE_DEPTH);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height < rgbc_pkg::GEOM_MIN) begin
      eff_h = rgbc_pkg::GEOM_MIN;
    end else if (frame_height > rgbc_pkg::GEOM_W'(rgbc_pkg::MAX_HEIGHT)) begin
      eff_h = rgbc_pkg::GEOM_W'(rgbc_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  assign last_col = rgbc_pkg::POS_W'(eff_w - rgbc_pkg::GEOM_W'(1));
  assign last_row = rgbc_pkg::POS_W'(eff_h - rgbc_pkg::GEOM_W'(1));

  // ------------------------------------------------------------- handshake
  assign out_take = !out_valid || result.ready;
  assign pop      = out_take && (res_valid != 3'b000);
  assign en       = (res_valid == 3'b000) || (pop && (rem_mask == 3'b000));
  assign accept   = pixel.valid && en;
  assign pixel.ready = en;

  // ------------------------------------------------------ position counters
  always_comb begin
    col_next = col;
    row_next = row;
    if (accept) begin
      if (col == last_col) begin
        col_next = '0;
        row_next = (row == last_row) ? '0 : row + rgbc_pkg::POS_W'(1);
      end else begin
        col_next = col + rgbc_pkg::POS_W'(1);
      end
    end
    if (geom_write) begin
      col_next = '0;
      row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // ----------------------------------------------- entry clip and line read
  always_comb begin
    clipped.red   = (pixel.red_in > pixel_ceiling) ? pixel_ceiling : pixel.red_in;
    clipped.green = (pixel.green_in > pixel_ceiling) ? pixel_ceiling : pixel.green_in;
    clipped.blue  = (pixel.blue_in > pixel_ceiling) ? pixel_ceiling : pixel.blue_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= clipped;
      s1_col  <= col;
      s1_row  <= row;
      line_rd <= line_store[col[rgbc_pkg::LINE_AW-1:0]];
    end
  end

  // write back: older row drops out, the new pixel joins
  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      line_store[s1_col[rgbc_pkg::LINE_AW-1:0]] <= {s1_pix, col_new[1]};
    end
  end

  // ------------------------------------------------- window and multiplies
  assign krow[0] = kernel_row_top;
  assign krow[1] = kernel_row_middle;
  assign krow[2] = kernel_row_bottom;

  assign col_new[0] = rgbc_pkg::pixel_t'(line_rd[rgbc_pkg::PIXEL_W-1:0]);
  assign col_new[1] = rgbc_pkg::pixel_t'(line_rd[2*rgbc_pkg::PIXEL_W-1:rgbc_pkg::PIXEL_W]);
  assign col_new[2] = s1_pix;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      grid[i][0] = win_far[i];
      grid[i][1] = win_near[i];
      grid[i][2] = col_new[i];
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[c][i][j] =
            $signed({1'b0, grid[i][j][rgbc_pkg::CHAN_W*c +: rgbc_pkg::CHAN_W]}) *
            $signed(krow[i][rgbc_pkg::COEF_BITS*j +: rgbc_pkg::COEF_BITS]);
        end
      end
    end
  end

  always_comb begin
    s1_meta.centre      = win_near[1];
    s1_meta.newer       = col_new[1];
    s1_meta.pix         = s1_pix;
    s1_meta.column      = s1_col;
    s1_meta.row         = s1_row;
    s1_meta.emit_prev   = (s1_col != '0) && (s1_row != '0);
    s1_meta.do_conv     = (s1_col > rgbc_pkg::POS_W'(1)) && (s1_row > rgbc_pkg::POS_W'(1));
    s1_meta.emit_rowend = (s1_col == last_col) && (s1_row != '0);
    s1_meta.emit_self   = (s1_row == last_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_far[i]  <= '0;
        win_near[i] <= '0;
      end
    end else if (en && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win_far[i]  <= win_near[i];
        win_near[i] <= col_new[i];
      end
    end
  end

  // ------------------------------------------------------------ adder tree
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        rowsum[c][i] = rgbc_pkg::ROWSUM_W'(s2_prod[c][i][0]) +
                       rgbc_pkg::ROWSUM_W'(s2_prod[c][i][1]) +
                       rgbc_pkg::ROWSUM_W'(s2_prod[c][i][2]);
      end
      total[c] = rgbc_pkg::SUM_W'(s3_rowsum[c][0]) +
                 rgbc_pkg::SUM_W'(s3_rowsum[c][1]) +
                 rgbc_pkg::SUM_W'(s3_rowsum[c][2]);
      conv_chan[c] = clip_sum(total[c], pixel_ceiling);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod   <= prod;
      s2_meta   <= s1_meta;
      s3_rowsum <= rowsum;
      s3_meta   <= s2_meta;
    end
  end

  // ---------------------------------------------------------- result slots
  assign conv_pix.red   = conv_chan[0];
  assign conv_pix.green = conv_chan[1];
  assign conv_pix.blue  = conv_chan[2];

  always_comb begin
    slot_new[0].pix    = s3_meta.do_conv ? conv_pix : s3_meta.centre;
    slot_new[0].column = s3_meta.column - rgbc_pkg::POS_W'(1);
    slot_new[0].row    = s3_meta.row - rgbc_pkg::POS_W'(1);
    slot_new[0].last   = 1'b0;
    slot_new[1].pix    = s3_meta.newer;
    slot_new[1].column = last_col;
    slot_new[1].row    = s3_meta.row - rgbc_pkg::POS_W'(1);
    slot_new[1].last   = 1'b0;
    slot_new[2].pix    = s3_meta.pix;
    slot_new[2].column = s3_meta.column;
    slot_new[2].row    = s3_meta.row;
    slot_new[2].last   = 1'b0;
  end

  always_comb begin
    if (res_valid[0]) begin
      sel_idx = 2'd0;
    end else if (res_valid[1]) begin
      sel_idx = 2'd1;
    end else begin
      sel_idx = 2'd2;
    end
    sel_mask = 3'b001 << sel_idx;
    rem_mask = res_valid & ~sel_mask;
    last_sel = (rem_mask == 3'b000);
    out_pick      = res_slot[sel_idx];
    out_pick.last = last_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= '0;
    end else if (en) begin
      res_valid <= s3_valid ? {s3_meta.emit_self, s3_meta.emit_rowend, s3_meta.emit_prev}
                            : 3'b000;
    end else if (pop) begin
      res_valid <= rem_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_slot <= slot_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= out_pick;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_red     = out_data.pix.red;
  assign result.out_green   = out_data.pix.green;
  assign result.out_blue    = out_data.pix.blue;
  assign result.out_column  = out_data.column;
  assign result.out_row     = out_data.row;
  assign result.last_of_run = out_data.last;

  // ------------------------------------------------------------ assertions
  a_accept_enters_window: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach the window stage");

  a_column_in_frame: assert property (@(posedge clk) disable iff (rst)
    col <= last_col)
    else $error("column counter beyond frame width");

  a_line_port_conflict: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid |-> col[rgbc_pkg::LINE_AW-1:0] != s1_col[rgbc_pkg::LINE_AW-1:0])
    else $error("line store read and write back hit the same column");

  a_last_beat_frees_slots: assert property (@(posedge clk) disable iff (rst)
    pop && last_sel |-> en)
    else $error("final beat of a pixel did not release the pipeline");

  a_slots_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !last_sel |=> res_valid == $past(rem_mask))
    else $error("result slot not cleared after its beat");

endmodule
